@@ hdl/cdg_pkg.sv @@
// cdg_pkg: widths, register indexes and shared types for the gradient edge block.
// Used by cdg_sqrt and central_difference_gradient_edge. No dependencies.
`timescale 1ns / 1ps

package cdg_pkg;

   localparam int PIX_W      = 8;    // grey pixel
   localparam int GRAD_W     = 9;    // signed doubled difference
   localparam int MAG_W      = 12;   // Q9.3 magnitude
   localparam int CFG_W      = 12;   // widest register, also csr data width
   localparam int ROW_W      = 12;   // row counter
   localparam int THR_W      = 8;    // edge threshold
   localparam int SQ_W       = 16;   // one squared difference
   localparam int SUM_W      = 17;   // sum of two squares
   localparam int RAD_W      = 2 * MAG_W;  // root radicand, sum scaled by 64
   localparam int REM_W      = MAG_W + 4;  // root partial remainder
   localparam int ROOT_CNT_W = 4;    // counts MAG_W root steps
   localparam int CSR_IDX_W  = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_EDGE_THRESHOLD = 2'd2;

   localparam logic [CFG_W-1:0] WIDTH_RESET     = 12'd640;
   localparam logic [CFG_W-1:0] HEIGHT_RESET    = 12'd480;
   localparam logic [THR_W-1:0] THRESHOLD_RESET = 8'd10;

   localparam logic [MAG_W-1:0] MAG_MAX = 12'd2885;

   // square-root unit status
   typedef struct packed {
      logic busy;
      logic done;
   } cdg_root_stat_type;

endpackage

@@ hdl/cdg_sqrt.sv @@
// cdg_sqrt: iterative integer square root, one result bit per cycle.
// Depends on cdg_pkg (widths, status struct).
`timescale 1ns / 1ps

module cdg_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [cdg_pkg::RAD_W-1:0]     radicand,
   output logic [cdg_pkg::MAG_W-1:0]     root,
   output cdg_pkg::cdg_root_stat_type    stat
);
   import cdg_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [ROOT_CNT_W-1:0] cnt_ff, cnt_in;
   logic [RAD_W-1:0]      rad_ff, rad_in;
   logic [REM_W-1:0]      rem_ff, rem_in;
   logic [MAG_W-1:0]      root_ff, root_in;

   logic [REM_W-1:0]      rem_sh;
   logic [REM_W-1:0]      trial;

   // restoring digit step: bring down two radicand bits, try root*4+1
   always_comb begin
      rem_sh = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1 -: 2]};
      trial  = REM_W'({root_ff, 2'b01});
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = '0;
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rad_in = {rad_ff[RAD_W-3:0], 2'b00};
         cnt_in = cnt_ff + 1'b1;
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[MAG_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[MAG_W-2:0], 1'b0};
         end
         if (cnt_ff == ROOT_CNT_W'(MAG_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign root      = root_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

@@ hdl/central_difference_gradient_edge.sv @@
// central_difference_gradient_edge: streaming central-difference gradient,
// Q9.3 magnitude and edge flag over two line buffers. Depends on cdg_pkg, cdg_sqrt.
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_ready  req_pixel, req_drain
// rsp_      out        rsp_valid / rsp_ready  rsp_grad_x, rsp_grad_y, rsp_magnitude,
//                                             rsp_edge_res, rsp_frame_end
// csr_      in         csr_valid / csr_ready  csr_index, csr_data
//
// Order: one item at a time. A pixel or drain that yields a result goes from transfer
//   to result through line read, difference/square, sum/compare, 12 root steps and
//   output load. A first-row pixel is only read and written back; an ignored drain
//   is taken without leaving the idle state.
// Reset: synchronous; counters and handshakes clear, config loads its defaults.
//   Line buffers get no clearing pass: an entry reads garbage until written.
// Stalls: the result sits in an output register, so the next item is taken while it
//   waits; the root stage holds its answer until that register frees up.
// csr_ready is always high; configuration is meant to change only while idle.

module central_difference_gradient_edge #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                              clock,
   input  logic                              reset,
   // pixel input
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [cdg_pkg::PIX_W-1:0]         req_pixel,
   input  logic                              req_drain,
   // result output
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [cdg_pkg::GRAD_W-1:0] rsp_grad_x,
   output logic signed [cdg_pkg::GRAD_W-1:0] rsp_grad_y,
   output logic [cdg_pkg::MAG_W-1:0]         rsp_magnitude,
   output logic                              rsp_edge_res,
   output logic                              rsp_frame_end,
   // register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [cdg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cdg_pkg::CFG_W-1:0]         csr_data
);
   import cdg_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH);
   // wide enough for the width register and for MAX_WIDTH itself
   localparam int WW = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;

   localparam logic [1:0] S_IDLE = 2'd0;  // take next item, read line buffers
   localparam logic [1:0] S_CALC = 2'd1;  // write back, differences and squares
   localparam logic [1:0] S_SUM  = 2'd2;  // sum of squares, threshold, start root
   localparam logic [1:0] S_ROOT = 2'd3;  // wait for root, load output

   // ---------------- configuration ----------------
   logic [CFG_W-1:0] width_ff, width_in;
   logic [CFG_W-1:0] height_ff, height_in;
   logic [THR_W-1:0] thresh_ff, thresh_in;

   assign csr_ready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      thresh_in = thresh_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_IMAGE_WIDTH:    width_in  = csr_data;
            REG_IMAGE_HEIGHT:   height_in = csr_data;
            REG_EDGE_THRESHOLD: thresh_in = csr_data[THR_W-1:0];
            default:            ;
         endcase
      end
   end

   // effective sizes: width clamped to 1..MAX_WIDTH, height of zero taken as one
   logic [WW-1:0]    width_eff;
   logic [ROW_W-1:0] height_eff;

   always_comb begin
      if (width_ff == '0)
         width_eff = WW'(1);
      else if (WW'(width_ff) > WW'(MAX_WIDTH))
         width_eff = WW'(MAX_WIDTH);
      else
         width_eff = WW'(width_ff);
      height_eff = (height_ff == '0) ? ROW_W'(1) : height_ff;
   end

   // ---------------- control ----------------
   logic [1:0]       state_ff, state_in;
   logic [AW-1:0]    col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   logic             accept;
   logic             draining;
   logic [AW-1:0]    cur_col;
   logic [ROW_W-1:0] cur_row;
   logic             last_col;
   logic             ignore_drain;
   logic [AW-1:0]    rd_left, rd_right;

   // item context held for the later stages
   logic [AW-1:0]    c_ff;
   logic [PIX_W-1:0] px_ff;
   logic             drain_ff;
   logic             has_res_ff;
   logic             gx_en_ff;
   logic             gy_en_ff;
   logic             frame_end_ff;

   // line buffer read data
   logic [PIX_W-1:0] up_c_ff, up_l_ff, mid_c_ff, mid_r_ff;

   // arithmetic registers
   logic signed [GRAD_W-1:0] gx_ff, gy_ff;
   logic [SQ_W-1:0]          gx2_ff, gy2_ff, t2_ff;
   logic                     edge_ff;

   logic                     root_start;
   logic [MAG_W-1:0]         root_val;
   cdg_root_stat_type        root_stat;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     out_free;
   logic                     out_load;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign draining  = (row_ff >= height_eff);

   // a pixel in the drain phase abandons the old frame and starts at row 0, column 0
   always_comb begin
      if (!req_drain && draining) begin
         cur_col = '0;
         cur_row = '0;
      end else begin
         cur_col = col_ff;
         cur_row = row_ff;
      end
      last_col     = (WW'(cur_col) + WW'(1)) >= width_eff;
      ignore_drain = req_drain && !draining;
      rd_left      = (cur_col == '0) ? '0 : cur_col - AW'(1);
      rd_right     = (cur_col == AW'(MAX_WIDTH - 1)) ? '0 : cur_col + AW'(1);
   end

   // counters advance at transfer; the datapath works from the held column
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept && !ignore_drain) begin
         if (req_drain) begin
            if (last_col) begin
               col_in = '0;
               row_in = '0;
            end else begin
               col_in = col_ff + AW'(1);
            end
         end else begin
            if (last_col) begin
               col_in = '0;
               row_in = cur_row + ROW_W'(1);
            end else begin
               col_in = cur_col + AW'(1);
               row_in = cur_row;
            end
         end
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign out_load = (state_ff == S_ROOT) && root_stat.done && out_free;

   always_comb begin
      state_in   = state_ff;
      root_start = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept && !ignore_drain)
               state_in = S_CALC;
         end
         S_CALC: begin
            state_in = has_res_ff ? S_SUM : S_IDLE;
         end
         S_SUM: begin
            root_start = 1'b1;
            state_in   = S_ROOT;
         end
         S_ROOT: begin
            if (out_load)
               state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
         thresh_ff    <= THRESHOLD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         thresh_ff    <= thresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         c_ff         <= cur_col;
         px_ff        <= req_pixel;
         drain_ff     <= req_drain;
         has_res_ff   <= req_drain || (cur_row != '0);
         gx_en_ff     <= (cur_col != '0) && !last_col;
         gy_en_ff     <= !req_drain && (cur_row != '0) && (cur_row != ROW_W'(1));
         frame_end_ff <= req_drain && last_col;
      end
   end

   // ---------------- line buffers ----------------
   // upper_mem[c]: row above the center row ahead of the scan, center row behind it.
   // middle_mem[c]: center row ahead of the scan, newest row behind it.
   logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
   logic [PIX_W-1:0] middle_mem [MAX_WIDTH];

   always_ff @(posedge clock) begin
      if (accept) begin
         up_c_ff  <= upper_mem[cur_col];
         up_l_ff  <= upper_mem[rd_left];
      end
      if (state_ff == S_CALC)
         upper_mem[c_ff] <= mid_c_ff;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mid_c_ff <= middle_mem[cur_col];
         mid_r_ff <= middle_mem[rd_right];
      end
      if (state_ff == S_CALC && !drain_ff)
         middle_mem[c_ff] <= px_ff;
   end

   // ---------------- arithmetic ----------------
   logic signed [GRAD_W-1:0]   gx_w, gy_w;
   logic signed [2*GRAD_W-1:0] gx_sq, gy_sq;
   logic [SQ_W-1:0]            t_sq;
   logic [SUM_W-1:0]           sum_sq;

   always_comb begin
      gx_w   = gx_en_ff ? ($signed({1'b0, mid_r_ff}) - $signed({1'b0, up_l_ff}))
                        : '0;
      gy_w   = gy_en_ff ? ($signed({1'b0, px_ff}) - $signed({1'b0, up_c_ff}))
                        : '0;
      gx_sq  = gx_w * gx_w;
      gy_sq  = gy_w * gy_w;
      t_sq   = SQ_W'(thresh_ff) * SQ_W'(thresh_ff);
      sum_sq = SUM_W'(gx2_ff) + SUM_W'(gy2_ff);
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_CALC) begin
         gx_ff  <= gx_w;
         gy_ff  <= gy_w;
         gx2_ff <= gx_sq[SQ_W-1:0];
         gy2_ff <= gy_sq[SQ_W-1:0];
         t2_ff  <= t_sq;
      end
      if (state_ff == S_SUM)
         edge_ff <= ({1'b0, sum_sq} > {t2_ff, 2'b00});
   end

   // magnitude in Q9.3 is the root of the sum scaled by 64
   cdg_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (RAD_W'({sum_sq, 6'b000000})),
      .root     (root_val),
      .stat     (root_stat)
   );

   // ---------------- output register ----------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load)
         rsp_valid_in = 1'b1;
      else if (rsp_ready)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_grad_x    <= gx_ff;
         rsp_grad_y    <= gy_ff;
         rsp_magnitude <= root_val;
         rsp_edge_res  <= edge_ff;
         rsp_frame_end <= frame_end_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // ---------------- checks ----------------
   a_root_holds_on_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROOT && root_stat.done && rsp_valid_ff && !rsp_ready)
      |=> state_ff == S_ROOT)
      else $error("root stage left while output register was full");

   a_pixel_goes_to_calc: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !req_drain) |=> state_ff == S_CALC)
      else $error("pixel transfer did not start write-back");

   a_mag_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_magnitude <= MAG_MAX)
      else $error("magnitude out of range");

   a_edge_needs_mag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_edge_res) |-> rsp_magnitude != '0)
      else $error("edge flagged on zero gradient");

   a_frame_end_flat_y: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_end) |-> rsp_grad_y == '0)
      else $error("last-row result carries vertical gradient");

endmodule

@@ tb/tb.sv @@
// tb: self-checking bench for central_difference_gradient_edge.
// Holds a line-buffer predictor and result scoreboard; depends on cdg_pkg and the RTL only.
`timescale 1ns / 1ps

module tb;
   import cdg_pkg::*;

   localparam int MAX_COLS      = 2048;      // line buffer depth, matches the DUT default
   localparam int RANDOM_ITEMS  = 1850;      // counted transfers in the random part
   localparam int SETTLE_CYCLES = 24;        // margin for the result path to empty
   localparam int HOLD_CYCLES   = 300;       // long receiver hold-off
   localparam int CYCLE_LIMIT   = 1_500_000; // several times the slowest clean run
   localparam int MAX_MSGS      = 200;       // keep the log short on a bad build

   typedef struct {
      logic signed [GRAD_W-1:0] grad_x;
      logic signed [GRAD_W-1:0] grad_y;
      logic [MAG_W-1:0]         magnitude;
      logic                     edge_res;
      logic                     frame_end;
   } grad_result_t;

   // Line-buffer predictor plus queue of expected gradients.
   class edge_scoreboard;
      logic [PIX_W-1:0] upper_row [MAX_COLS];
      logic [PIX_W-1:0] middle_row [MAX_COLS];
      int unsigned      col_idx;
      logic [ROW_W-1:0] row_idx;
      logic [CFG_W-1:0] width_reg;
      logic [CFG_W-1:0] height_reg;
      logic [THR_W-1:0] thresh_reg;
      grad_result_t     expected_grads [$];
      int unsigned      error_count;
      int unsigned      results_seen;

      function void clear();
         col_idx    = 0;
         row_idx    = '0;
         width_reg  = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
         thresh_reg = THRESHOLD_RESET;
         expected_grads.delete();
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
         case (idx)
            REG_IMAGE_WIDTH:    width_reg  = data;
            REG_IMAGE_HEIGHT:   height_reg = data;
            REG_EDGE_THRESHOLD: thresh_reg = data[THR_W-1:0];
            default: ;
         endcase
      endfunction

      function int unsigned cols_in_use();
         if (width_reg == 0) return 1;
         if (width_reg > MAX_COLS) return MAX_COLS;
         return int'(width_reg);
      endfunction

      function int unsigned rows_in_use();
         return (height_reg == 0) ? 1 : int'(height_reg);
      endfunction

      function bit in_drain_phase();
         return row_idx >= rows_in_use();
      endfunction

      // bit-by-bit integer square root
      function int unsigned int_root(longint unsigned v);
         longint unsigned root;
         longint unsigned trial;
         root = 0;
         for (int b = 15; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v) root = trial;
         end
         return int'(root);
      endfunction

      // Result for the centre row at column c; vertical difference given.
      function void predict_grad(int unsigned c, int unsigned w, int gy, bit last);
         int              gx;
         longint unsigned sum_sq;
         int unsigned     mag;
         int unsigned     thr;
         grad_result_t    r;
         gx = 0;
         if (c != 0 && c + 1 < w)
            gx = int'(middle_row[c + 1]) - int'(upper_row[c - 1]);
         sum_sq = longint'(gx * gx + gy * gy);
         mag = int_root(sum_sq * 64);
         thr = int'(thresh_reg);
         r.grad_x    = gx[GRAD_W-1:0];
         r.grad_y    = gy[GRAD_W-1:0];
         r.magnitude = mag[MAG_W-1:0];
         r.edge_res  = sum_sq > 4 * thr * thr;
         r.frame_end = last;
         expected_grads.push_back(r);
      endfunction

      // Notes one accepted transfer; returns 0 when the block ignores it.
      function bit note_item(logic [PIX_W-1:0] px, logic drain);
         int unsigned w;
         int unsigned c;
         bit          last;
         w = cols_in_use();
         if (drain) begin
            if (!in_drain_phase()) return 0;
            c = col_idx % MAX_COLS;
            last = col_idx + 1 >= w;
            predict_grad(c, w, 0, last);
            upper_row[c] = middle_row[c];
            if (last) begin
               col_idx = 0;
               row_idx = '0;
            end else begin
               col_idx++;
            end
            return 1;
         end
         // a pixel in the drain phase abandons the rest of the last row
         if (in_drain_phase()) begin
            col_idx = 0;
            row_idx = '0;
         end
         c = col_idx % MAX_COLS;
         if (row_idx > 0)
            predict_grad(c, w, (row_idx == 1) ? 0 : int'(px) - int'(upper_row[c]), 1'b0);
         upper_row[c]  = middle_row[c];
         middle_row[c] = px;
         if (col_idx + 1 >= w) begin
            col_idx = 0;
            row_idx = row_idx + 1'b1;
         end else begin
            col_idx++;
         end
         return 1;
      endfunction

      function void report(string msg);
         if (error_count < MAX_MSGS) $display("MISMATCH result %0d: %s", results_seen, msg);
         error_count++;
      endfunction

      function void check_result(grad_result_t got);
         grad_result_t want;
         results_seen++;
         if (expected_grads.size() == 0) begin
            report($sformatf("unexpected result gx=%0d gy=%0d mag=%0d",
                             got.grad_x, got.grad_y, got.magnitude));
            return;
         end
         want = expected_grads.pop_front();
         if (got.grad_x !== want.grad_x)
            report($sformatf("grad_x %0d, want %0d", got.grad_x, want.grad_x));
         if (got.grad_y !== want.grad_y)
            report($sformatf("grad_y %0d, want %0d", got.grad_y, want.grad_y));
         if (got.magnitude !== want.magnitude)
            report($sformatf("magnitude %0d, want %0d", got.magnitude, want.magnitude));
         if (got.edge_res !== want.edge_res)
            report($sformatf("edge_res %b, want %b", got.edge_res, want.edge_res));
         if (got.frame_end !== want.frame_end)
            report($sformatf("frame_end %b, want %b", got.frame_end, want.frame_end));
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic [PIX_W-1:0]         req_pixel;
   logic                     req_drain;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic signed [GRAD_W-1:0] rsp_grad_x;
   logic signed [GRAD_W-1:0] rsp_grad_y;
   logic [MAG_W-1:0]         rsp_magnitude;
   logic                     rsp_edge_res;
   logic                     rsp_frame_end;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index;
   logic [CFG_W-1:0]         csr_data;

   edge_scoreboard sb = new();
   int unsigned    sender_idle_pct = 0;
   int unsigned    stall_pct = 0;
   bit             hold_request = 1'b0;
   int unsigned    items_sent = 0;
   int unsigned    cycle_count = 0;

   central_difference_gradient_edge #(.MAX_WIDTH(MAX_COLS)) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_pixel     (req_pixel),
      .req_drain     (req_drain),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_grad_x    (rsp_grad_x),
      .rsp_grad_y    (rsp_grad_y),
      .rsp_magnitude (rsp_magnitude),
      .rsp_edge_res  (rsp_edge_res),
      .rsp_frame_end (rsp_frame_end),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Offers one item; random idle cycles first, then holds valid until the transfer.
   task automatic send_item(input logic [PIX_W-1:0] px, input logic drain);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= px;
      req_drain <= drain;
      do @(posedge clock); while (!req_ready);
      if (sb.note_item(px, drain)) items_sent++;
   endtask

   function automatic logic [PIX_W-1:0] any_pixel();
      return PIX_W'($urandom_range(255));
   endfunction

   // Sender pauses until every expected result is back and the pipe has emptied.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.expected_grads.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes all three registers back to back; valid stays high across them.
   task automatic configure(input int unsigned w, input int unsigned h, input int unsigned t);
      logic [CFG_W-1:0]     vals [3];
      logic [CSR_IDX_W-1:0] regs [3];
      vals = '{CFG_W'(w), CFG_W'(h), CFG_W'(t)};
      regs = '{REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_EDGE_THRESHOLD};
      for (int i = 0; i < 3; i++) begin
         csr_valid <= 1'b1;
         csr_index <= regs[i];
         csr_data  <= vals[i];
         do @(posedge clock); while (!csr_ready);
         sb.write_reg(regs[i], vals[i]);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic drain_row();
      while (sb.in_drain_phase()) send_item(any_pixel(), 1'b1);
   endtask

   // One frame of random pixels. Stray drains inside the frame are ignored by the
   // block; a cut-short frame stops draining early so the next pixel abandons the row.
   task automatic send_frame(input bit cut_short);
      send_item(any_pixel(), 1'b0);
      while (!sb.in_drain_phase()) begin
         if ($urandom_range(15) == 0) send_item(any_pixel(), 1'b1);
         else send_item(any_pixel(), 1'b0);
      end
      while (sb.in_drain_phase() && !(cut_short && $urandom_range(3) == 0))
         send_item(any_pixel(), 1'b1);
   endtask

   task automatic random_run(input int run_idx);
      int unsigned w;
      int unsigned h;
      int unsigned t;
      int unsigned frames;
      w = ($urandom_range(9) == 0) ? $urandom_range(40, 11) : $urandom_range(10, 1);
      h = ($urandom_range(9) == 0) ? $urandom_range(12, 7) : $urandom_range(6, 1);
      case ($urandom_range(9))
         0, 1:    t = 0;
         2:       t = 255;
         default: t = $urandom_range(120);
      endcase
      frames = $urandom_range(3, 1);
      wait_idle();
      configure(w, h, t);
      // rotate through the idle mixes: none, sender, receiver, both
      case ((run_idx / 3) % 4)
         0:       begin sender_idle_pct = 0;  stall_pct = 0;  end
         1:       begin sender_idle_pct = 49; stall_pct = 0;  end
         2:       begin sender_idle_pct = 0;  stall_pct = 49; end
         default: begin sender_idle_pct = 34; stall_pct = 34; end
      endcase
      // receiver blocks for a while; the sender keeps offering until the block backs up
      if (run_idx % 20 == 3) hold_request = 1'b1;
      repeat (frames) send_frame($urandom_range(7) == 0);
   endtask

   // Result sink: checks each transfer, then picks ready for the next edge.
   initial begin : result_sink
      grad_result_t got;
      int unsigned  hold_left;
      hold_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got.grad_x    = rsp_grad_x;
            got.grad_y    = rsp_grad_y;
            got.magnitude = rsp_magnitude;
            got.edge_res  = rsp_edge_res;
            got.frame_end = rsp_frame_end;
            sb.check_result(got);
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !reset && ($urandom_range(99) >= stall_pct);
         end
      end
   end

   initial begin : stimulus
      logic [PIX_W-1:0] edge_img [9];
      int               run_idx;
      // 3x3 with a full-scale step both ways at the centre
      edge_img = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd128, 8'd255, 8'd255, 8'd255, 8'd255};
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_pixel <= '0;
      req_drain <= 1'b0;
      csr_valid <= 1'b0;
      csr_index <= REG_IMAGE_WIDTH;
      csr_data  <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      sb.clear();

      // Directed: lone drain outside the drain phase, then the largest positive
      // and negative gradients at thresholds 0 and 255.
      configure(3, 3, 0);
      send_item(any_pixel(), 1'b1);
      foreach (edge_img[i]) send_item(edge_img[i], 1'b0);
      drain_row();
      wait_idle();
      configure(3, 3, 255);
      foreach (edge_img[i]) send_item(~edge_img[i], 1'b0);
      drain_row();

      // Registers changed mid-frame: narrower than the current column, shorter.
      wait_idle();
      configure(8, 6, 40);
      repeat (2 * 8 + 3) send_item(any_pixel(), 1'b0);
      wait_idle();
      configure(2, 4, 40);
      send_frame(1'b0);

      // Size extremes: one full-width row, then one column 2048 rows high.
      wait_idle();
      configure(MAX_COLS, 1, 60);
      send_frame(1'b0);
      wait_idle();
      configure(1, 2048, 60);
      send_frame(1'b0);

      items_sent = 0;
      for (run_idx = 0; items_sent < RANDOM_ITEMS; run_idx++) random_run(run_idx);

      wait_idle();
      if (sb.error_count == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
